@@ rtl/ues_pkg.sv @@
// ----------------------------------------------------------------------------
// ues_pkg
// Types and constants shared by the UTF-8 emoji strip filter.
// ----------------------------------------------------------------------------
package ues_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } ues_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } ues_out_t;

    // four-byte lead range
    localparam logic [7:0] LEAD_LO    = 8'hF0;
    localparam logic [7:0] LEAD_HI    = 8'hF4;
    // variation selector EF B8 80..8F
    localparam logic [7:0] VS_B0      = 8'hEF;
    localparam logic [7:0] VS_B1      = 8'hB8;
    localparam logic [7:0] VS_B2_LO   = 8'h80;
    localparam logic [7:0] VS_B2_HI   = 8'h8F;
    // zero-width joiner E2 80 8D
    localparam logic [7:0] ZWJ_B0     = 8'hE2;
    localparam logic [7:0] ZWJ_B1     = 8'h80;
    localparam logic [7:0] ZWJ_B2     = 8'h8D;

    // most results one string-end item can give
    localparam int unsigned MAX_RES   = 5;

    function automatic logic is_marker_triple(input logic [7:0] a,
                                              input logic [7:0] b,
                                              input logic [7:0] c);
        logic vs;
        logic zwj;
        vs  = (a == VS_B0) && (b == VS_B1) && (c >= VS_B2_LO) && (c <= VS_B2_HI);
        zwj = (a == ZWJ_B0) && (b == ZWJ_B1) && (c == ZWJ_B2);
        return vs || zwj;
    endfunction

endpackage

@@ rtl/utf8_emoji_strip_filter.sv @@
// ----------------------------------------------------------------------------
// utf8_emoji_strip_filter
// Drops four-byte sequences (lead F0..F4 plus three bytes; a group cut short
// by string end is passed on), then drops variation selectors and zero-width joiners from the remaining byte stream.
// ----------------------------------------------------------------------------
// The first result of an item is valid the cycle after the item is taken.
// One byte per cycle while the output takes each result; a non-final item gives at most one result.
// A final item gives one to five results, drained one per cycle while m_ready is high from the
// result buffer; the next item is taken in the cycle its last result leaves.
// Reset (aresetn low, synchronous) empties both hold stages and the buffer.
module utf8_emoji_strip_filter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ues_pkg::ues_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ues_pkg::ues_out_t m_data
);
    import ues_pkg::*;

    // stage state
    logic [7:0] lead_hold_reg   [3];
    logic [1:0] lead_count_reg;
    logic [7:0] window_hold_reg [2];
    logic [1:0] window_count_reg;

    // result buffer
    ues_out_t   ob_reg [MAX_RES];
    logic [2:0] ob_rem_reg;
    logic [2:0] ob_idx_reg;

    // next values
    logic [7:0] lead_hold_next   [3];
    logic [1:0] lead_count_next;
    logic [7:0] window_hold_next [2];
    logic [1:0] window_count_next;
    ues_out_t   ob_next [MAX_RES];
    logic [2:0] ob_rem_next;
    logic [2:0] ob_idx_next;

    // per-item working values
    logic [7:0] push_v [3];
    logic [1:0] push_n;
    logic [7:0] emit_v [MAX_RES];
    logic [2:0] emit_n;
    logic [7:0] cur_b;
    logic       cur_last;
    logic       s_fire;
    logic       m_fire;

    assign cur_b    = s_data.in_byte;
    assign cur_last = s_data.in_last;

    assign m_valid = (ob_rem_reg != 3'd0);
    assign m_data  = ob_reg[ob_idx_reg];
    assign m_fire  = m_valid && m_ready;
    assign s_ready = (ob_rem_reg == 3'd0) || ((ob_rem_reg == 3'd1) && m_ready);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        lead_hold_next    = lead_hold_reg;
        lead_count_next   = lead_count_reg;
        window_hold_next  = window_hold_reg;
        window_count_next = window_count_reg;
        push_v[0] = cur_b;
        push_v[1] = 8'h00;
        push_v[2] = 8'h00;
        push_n    = 2'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            emit_v[i] = 8'h00;
        end
        emit_n = 3'd0;

        // stage one: four-byte sequence tracking
        if (lead_count_reg != 2'd0) begin
            if (lead_count_reg == 2'd3) begin
                lead_count_next = 2'd0;
            end else begin
                lead_hold_next[lead_count_reg] = cur_b;
                lead_count_next = lead_count_reg + 2'd1;
            end
        end else if (cur_b >= LEAD_LO && cur_b <= LEAD_HI && !cur_last) begin
            lead_hold_next[0] = cur_b;
            lead_count_next   = 2'd1;
        end else begin
            push_n = 2'd1;
        end

        // string end inside a lead group: held bytes go on to stage two
        if (cur_last && lead_count_next != 2'd0) begin
            push_v[0] = lead_hold_next[0];
            push_v[1] = lead_hold_next[1];
            push_v[2] = lead_hold_next[2];
            push_n    = lead_count_next;
        end
        if (cur_last) begin
            lead_count_next = 2'd0;
        end

        // stage two: three-byte window, at most three pushes per item
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < push_n) begin
                if (window_count_next == 2'd2) begin
                    if (is_marker_triple(window_hold_next[0], window_hold_next[1],
                                         push_v[k])) begin
                        window_count_next = 2'd0;
                    end else begin
                        emit_v[emit_n] = window_hold_next[0];
                        emit_n = emit_n + 3'd1;
                        window_hold_next[0] = window_hold_next[1];
                        window_hold_next[1] = push_v[k];
                    end
                end else begin
                    window_hold_next[window_count_next[0]] = push_v[k];
                    window_count_next = window_count_next + 2'd1;
                end
            end
        end

        // flush the window at string end
        if (cur_last) begin
            for (int k = 0; k < 2; k++) begin
                if (2'(k) < window_count_next) begin
                    emit_v[emit_n] = window_hold_next[k];
                    emit_n = emit_n + 3'd1;
                end
            end
            window_count_next = 2'd0;
        end

        for (int i = 0; i < MAX_RES; i++) begin
            ob_next[i].out_byte  = emit_v[i];
            ob_next[i].out_valid = 1'b1;
            ob_next[i].out_last  = cur_last && (3'(i + 1) == emit_n);
        end
        if (cur_last && emit_n == 3'd0) begin
            // empty end marker
            ob_next[0].out_byte  = 8'h00;
            ob_next[0].out_valid = 1'b0;
            ob_next[0].out_last  = 1'b1;
        end

        ob_rem_next = ob_rem_reg;
        ob_idx_next = ob_idx_reg;
        if (s_fire) begin
            ob_rem_next = (cur_last && emit_n == 3'd0) ? 3'd1 : emit_n;
            ob_idx_next = 3'd0;
        end else if (m_fire) begin
            ob_rem_next = ob_rem_reg - 3'd1;
            ob_idx_next = ob_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_count_reg   <= 2'd0;
            window_count_reg <= 2'd0;
            ob_rem_reg       <= 3'd0;
            ob_idx_reg       <= 3'd0;
        end else begin
            if (s_fire) begin
                lead_count_reg   <= lead_count_next;
                window_count_reg <= window_count_next;
            end
            ob_rem_reg <= ob_rem_next;
            ob_idx_reg <= ob_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            lead_hold_reg   <= lead_hold_next;
            window_hold_reg <= window_hold_next;
            ob_reg          <= ob_next;
        end
    end

    // a byte in the middle of a string yields at most one result
    a_mid_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !s_data.in_last |=> ob_rem_reg <= 3'd1)
        else $error("mid-string item gave more than one result");

    // string end leaves both stages empty and something to deliver
    a_end_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.in_last |=> m_valid && lead_count_reg == 2'd0
                                     && window_count_reg == 2'd0)
        else $error("string end did not flush");

    // the last flag only rides on the final buffered result
    a_last_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_last |-> ob_rem_reg == 3'd1)
        else $error("last flag before final result");

    // an empty result is always the end marker
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.out_valid |-> m_data.out_last)
        else $error("empty result without last flag");

endmodule
